// ===== rtl/core/sle_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted list engine: capacity, field widths, request kinds,
// status codes and the structs passed between the cells, the core and the output stage.
// No dependencies.
package sle_pkg;

   // Storage geometry.
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the words.
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT       = 2'd0,
      KIND_REMOVE_FIRST = 2'd1,
      KIND_REMOVE_LAST  = 2'd2,
      KIND_FIND         = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Broadcast from the core to every cell.
   typedef struct packed {
      logic                     ins_en;
      logic                     rmf_en;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   // Compare flags that a cell reports.
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_stat_type;

   // One result word.
   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     found;
      logic [POS_W-1:0]         position;
      logic [COUNT_W-1:0]       count;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

endpackage

// ===== rtl/core/sle_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying kind and value.
// Depends on sle_pkg.
interface sle_req_if;
   logic                              valid;
   logic                              ready;
   logic [sle_pkg::KIND_W-1:0]        kind;
   logic signed [sle_pkg::DATA_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

// ===== rtl/core/sle_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result word.
// Depends on sle_pkg.
interface sle_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sle_pkg::DATA_W-1:0] data;
   logic                              found;
   logic [sle_pkg::POS_W-1:0]         position;
   logic [sle_pkg::COUNT_W-1:0]       count;
   logic [sle_pkg::STATUS_W-1:0]      status;

   modport source (output valid, data, found, position, count, status, input ready);
   modport sink   (input valid, data, found, position, count, status, output ready);
endinterface

// ===== rtl/core/sorted_list_engine.sv =====
`timescale 1ns / 1ps
// Sorted list engine: a chain of CAPACITY cells keeps signed values in ascending order.
// Response: a request accepted at one edge has its response valid after that edge.
// Throughput: one request per cycle while responses are taken; inserts and front removals shift the chain.
// The rate is set by the compare and shift in each cell plus the find and last-entry selects.
// Reset (synchronous, active high) clears the count and the output valid; entries stay as is.
// Depends on sle_pkg, sle_req_if, sle_rsp_if, sle_cell and sle_out_reg.
module sorted_list_engine (
   input  logic      clock,
   input  logic      reset,
   sle_req_if.sink   req_chan,
   sle_rsp_if.source rsp_chan
);

   localparam int CAP = sle_pkg::CAPACITY;

   logic                              accept;
   logic                              take_ready;
   sle_pkg::kind_type                 kind;
   logic [sle_pkg::CNT_W-1:0]         count_ff;
   logic [sle_pkg::CNT_W-1:0]         count_in;
   logic                              full;
   logic                              empty;
   sle_pkg::cell_ctrl_type            ctrl;
   logic [CAP-1:0]                    occ;
   logic [CAP-1:0]                    lt_vec;
   logic [CAP-1:0]                    eq_vec;
   logic signed [sle_pkg::DATA_W-1:0] entry_w [CAP];
   sle_pkg::cell_stat_type            stat_w [CAP];
   logic signed [sle_pkg::DATA_W-1:0] last_entry;
   logic [sle_pkg::IDX_W-1:0]         first_pos;
   sle_pkg::rsp_type                  word;

   assign kind            = sle_pkg::kind_type'(req_chan.kind);
   assign req_chan.ready  = take_ready;
   assign accept          = req_chan.valid && take_ready;
   assign full            = (count_ff == sle_pkg::CNT_W'(CAP));
   assign empty           = (count_ff == '0);

   // Broadcast the request to the chain.
   always_comb begin
      ctrl.value  = req_chan.value;
      ctrl.ins_en = accept && (kind == sle_pkg::KIND_INSERT) && !full;
      ctrl.rmf_en = accept && (kind == sle_pkg::KIND_REMOVE_FIRST) && !empty;
   end

   // The chain of cells.
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      assign occ[i]    = (count_ff > sle_pkg::CNT_W'(i));
      assign lt_vec[i] = stat_w[i].lt;
      assign eq_vec[i] = stat_w[i].eq;

      if (i == 0) begin : g_head
         sle_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_lt     (1'b1),
            .left_entry  (req_chan.value),
            .right_entry (entry_w[(CAP > 1) ? 1 : 0]),
            .entry       (entry_w[i]),
            .stat        (stat_w[i])
         );
      end else if (i == CAP - 1) begin : g_tail
         sle_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_lt     (lt_vec[i-1]),
            .left_entry  (entry_w[i-1]),
            .right_entry (entry_w[i]),
            .entry       (entry_w[i]),
            .stat        (stat_w[i])
         );
      end else begin : g_mid
         sle_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_lt     (lt_vec[i-1]),
            .left_entry  (entry_w[i-1]),
            .right_entry (entry_w[i+1]),
            .entry       (entry_w[i]),
            .stat        (stat_w[i])
         );
      end
   end

   // The last occupied cell is the one whose right neighbor is empty.
   // Equal entries are contiguous, so the first one is where an equal run starts.
   always_comb begin
      last_entry = '0;
      first_pos  = '0;
      for (int i = 0; i < CAP; i++) begin
         if (occ[i] && ((i == CAP - 1) || !occ[(i + 1) % CAP])) begin
            last_entry = last_entry | entry_w[i];
         end
         if (eq_vec[i] && ((i == 0) || !eq_vec[(i + CAP - 1) % CAP])) begin
            first_pos = first_pos | sle_pkg::IDX_W'(i);
         end
      end
   end

   // Build the response word and the next count.
   always_comb begin
      count_in      = count_ff;
      word.data     = '0;
      word.found    = 1'b0;
      word.position = '0;
      word.status   = sle_pkg::STATUS_OK;
      unique case (kind)
         sle_pkg::KIND_INSERT: begin
            if (full) begin
               word.status = sle_pkg::STATUS_FULL;
            end else begin
               word.data = req_chan.value;
               count_in  = count_ff + 1'b1;
            end
         end
         sle_pkg::KIND_REMOVE_FIRST: begin
            if (empty) begin
               word.status = sle_pkg::STATUS_EMPTY;
            end else begin
               word.data = entry_w[0];
               count_in  = count_ff - 1'b1;
            end
         end
         sle_pkg::KIND_REMOVE_LAST: begin
            if (empty) begin
               word.status = sle_pkg::STATUS_EMPTY;
            end else begin
               word.data = last_entry;
               count_in  = count_ff - 1'b1;
            end
         end
         sle_pkg::KIND_FIND: begin
            word.data     = req_chan.value;
            word.found    = |eq_vec;
            word.position = sle_pkg::POS_W'(first_pos);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      word.count = sle_pkg::COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // Response register.
   sle_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (take_ready),
      .in_word  (word),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // The count never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sle_pkg::CNT_W'(CAP))
      else $error("entry count above capacity");

   // An insert into a store with room adds exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind == sle_pkg::KIND_INSERT) && !full)
      |=> (count_ff == sle_pkg::CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not add one entry");

   // A removal from an empty store leaves the count alone.
   a_empty_remove_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && ((kind == sle_pkg::KIND_REMOVE_FIRST) ||
                           (kind == sle_pkg::KIND_REMOVE_LAST)))
      |=> $stable(count_ff))
      else $error("empty removal changed the count");

   // A hit can only come from an occupied cell.
   a_eq_occupied: assert property (@(posedge clock) disable iff (reset)
      ((eq_vec & ~occ) == '0))
      else $error("match reported by an empty cell");
`endif

endmodule

// ===== rtl/core/sle_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
// Depends on sle_pkg.
module sle_cell (
   input  logic                                 clock,
   input  sle_pkg::cell_ctrl_type               ctrl,
   input  logic                                 occupied,
   input  logic                                 left_lt,
   input  logic signed [sle_pkg::DATA_W-1:0]    left_entry,
   input  logic signed [sle_pkg::DATA_W-1:0]    right_entry,
   output logic signed [sle_pkg::DATA_W-1:0]    entry,
   output sle_pkg::cell_stat_type               stat
);

   logic signed [sle_pkg::DATA_W-1:0] entry_ff;
   logic signed [sle_pkg::DATA_W-1:0] entry_in;

   // Compare the held entry with the request value.
   always_comb begin
      stat.lt = occupied && (entry_ff < ctrl.value);
      stat.eq = occupied && (entry_ff == ctrl.value);
   end

   // An insert keeps smaller entries, drops the value into the first cell that is
   // not smaller and shifts the rest right; a front removal shifts everything left.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (!stat.lt) begin
            entry_in = left_lt ? ctrl.value : left_entry;
         end
      end else if (ctrl.rmf_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/sle_out_reg.sv =====
`timescale 1ns / 1ps
// Output register for the response channel; a new word loads while the old one is taken.
// Depends on sle_pkg and sle_rsp_if.
module sle_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sle_pkg::rsp_type in_word,
   sle_rsp_if.source        rsp_chan
);

   logic             valid_ff;
   logic             valid_in;
   sle_pkg::rsp_type word_ff;

   assign in_ready = !valid_ff || rsp_chan.ready;

   // Valid stays set while a word waits or a new one replaces it.
   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.data     = word_ff.data;
   assign rsp_chan.found    = word_ff.found;
   assign rsp_chan.position = word_ff.position;
   assign rsp_chan.count    = word_ff.count;
   assign rsp_chan.status   = word_ff.status;

endmodule
